[design/tcfir_pkg.sv]
// Package for the two-channel low-pass FIR unit: item types, default sizes
// and the fixed coefficient table with its Q1.(COEF_BITS-1) rounding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcfir_pkg;

  // Fixed field widths of the request and result items.
  localparam int SAMPLE_FIELD_W = 18;

  // Defaults for the top-level parameters.
  localparam int TAP_COUNT_DEF   = 29;
  localparam int SAMPLE_BITS_DEF = 18;
  localparam int COEF_BITS_DEF   = 16;

  // Coefficients are tabulated as integers scaled by 10^12.
  localparam int      TABLE_LEN = 29;
  localparam longint  DEC_SCALE = 64'd1000000000000;

  typedef struct packed {
    logic                      channel;
    logic [SAMPLE_FIELD_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                      channel_out;
    logic [SAMPLE_FIELD_W-1:0] filtered;
    logic                      clipped;
  } out_item_t;

  // Symmetric table: entry k equals entry 28-k.
  function automatic longint coef_dec(input int idx);
    int     m;
    longint v;
    m = (idx <= 14) ? idx : 28 - idx;
    case (m)
      0:       v = -64'sd1542701735;
      1:       v = -64'sd2211477375;
      2:       v = -64'sd3286228748;
      3:       v = -64'sd4426511470;
      4:       v = -64'sd4758632276;
      5:       v = -64'sd3007677384;
      6:       v = 64'sd2192312852;
      7:       v = 64'sd11883096770;
      8:       v = 64'sd26376428080;
      9:       v = 64'sd44981528070;
      10:      v = 64'sd65962076190;
      11:      v = 64'sd86760722100;
      12:      v = 64'sd104456014900;
      13:      v = 64'sd116349831200;
      14:      v = 64'sd120542444300;
      default: v = 64'sd0;
    endcase
    return v;
  endfunction

  // Rounds a coefficient to cbits signed bits, half away from zero.
  // Taps past the end of the table are zero. Used at elaboration only.
  function automatic longint coef_quant(input int idx, input int cbits);
    longint          d;
    longint unsigned mag;
    longint unsigned q;
    d   = (idx < TABLE_LEN) ? coef_dec(idx) : 64'sd0;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q   = (mag * (64'd1 << (cbits - 1)) + DEC_SCALE / 2) / DEC_SCALE;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

endpackage
`default_nettype wire

[design/tcfir_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tcfir_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[design/tcfir_front.sv]
// Front end: accepts requests and holds them in a two-entry queue so that the
// filter engine and the request side stall independently. Uses tcfir_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcfir_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output      logic                sample_ready,
  input  wire tcfir_pkg::in_item_t sample_item,
  output      logic                job_valid,
  input  wire logic                job_ready,
  output      tcfir_pkg::in_item_t job_item
);

  tcfir_pkg::in_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign sample_ready = (count != 2'd2);
  assign job_valid    = (count != 2'd0);
  assign job_item     = slots[rd_ptr];
  assign push         = sample_valid && sample_ready;
  assign pop          = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= sample_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/tcfir_back.sv]
// Filter engine: one multiply-accumulate per tap over the channel's delay line,
// kept as a circular buffer in tcfir_ram, then rounding and saturation into an
// output register. Uses tcfir_pkg and tcfir_ram.
`timescale 1ns / 1ps
`default_nettype none
module tcfir_back #(
  parameter int TAP_COUNT   = tcfir_pkg::TAP_COUNT_DEF,
  parameter int SAMPLE_BITS = tcfir_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = tcfir_pkg::COEF_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 job_valid,
  output      logic                 job_ready,
  input  wire tcfir_pkg::in_item_t  job_item,
  output      logic                 result_valid,
  input  wire logic                 result_ready,
  output      tcfir_pkg::out_item_t result_item
);

  localparam int HIST_LEN = TAP_COUNT - 1;
  localparam int PTR_W    = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
  localparam int TAP_W    = $clog2(TAP_COUNT);
  localparam int PROD_W   = COEF_BITS + SAMPLE_BITS + 1;
  localparam int ACC_W    = PROD_W + 6;
  localparam int RAM_AW   = PTR_W + 1;
  localparam int RAM_D    = 2 ** RAM_AW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic signed [COEF_BITS-1:0] coef_tab [TAP_COUNT];

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_coef
    assign coef_tab[k] = COEF_BITS'(tcfir_pkg::coef_quant(k, COEF_BITS));
  end

  logic [1:0]             state;
  logic                   cur_ch;
  logic [SAMPLE_BITS-1:0] cur_x;
  logic [TAP_W-1:0]       tap;
  logic [PTR_W-1:0]       rp;
  logic [PTR_W-1:0]       wptr [2];
  logic [TAP_W-1:0]       fill [2];

  logic                   s1_vld;
  logic [TAP_W-1:0]       s1_tap;
  logic                   s2_vld;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic [SAMPLE_BITS-1:0] ram_rd_data;
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] operand;
  logic signed [PROD_W-1:0] prod_next;
  logic                   can_load;

  logic signed [ACC_W-1:0] biased;
  logic signed [ACC_W-1:0] y_full;
  logic [SAMPLE_BITS-1:0]  y_sat;
  logic                    clip;

  tcfir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_D)
  ) u_hist (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr ({cur_ch, wptr[cur_ch]}),
    .wr_data (cur_x),
    .rd_addr ({cur_ch, rp}),
    .rd_data (ram_rd_data)
  );

  assign job_ready = (state == ST_IDLE);
  assign can_load  = !result_valid || result_ready;
  assign ram_we    = (state == ST_FINISH) && can_load;

  // Tap 0 is the new sample; later taps read the delay line, where entries
  // never written since reset count as zero.
  always_comb begin
    if (s1_tap == '0) begin
      operand = cur_x;
    end else if (s1_tap <= fill[cur_ch]) begin
      operand = ram_rd_data;
    end else begin
      operand = '0;
    end
    prod_next = coef_tab[s1_tap] * $signed({1'b0, operand});
  end

  always_comb begin
    biased = acc + (ACC_W'(1) <<< (COEF_BITS - 2));
    y_full = biased >>> (COEF_BITS - 1);
    if (biased[ACC_W-1]) begin
      y_sat = '0;
      clip  = 1'b1;
    end else if (|y_full[ACC_W-1:SAMPLE_BITS]) begin
      y_sat = '1;
      clip  = 1'b1;
    end else begin
      y_sat = y_full[SAMPLE_BITS-1:0];
      clip  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      s1_vld       <= 1'b0;
      s2_vld       <= 1'b0;
      result_valid <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        wptr[c] <= '0;
        fill[c] <= '0;
      end
    end else begin
      s1_vld <= 1'b0;
      s2_vld <= s1_vld;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          s1_vld <= 1'b1;
          if (tap == TAP_W'(TAP_COUNT - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_vld && !s2_vld) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (can_load) begin
            result_valid <= 1'b1;
            wptr[cur_ch] <= (wptr[cur_ch] == PTR_W'(HIST_LEN - 1)) ? '0
                                                                   : wptr[cur_ch] + 1'b1;
            if (fill[cur_ch] != TAP_W'(HIST_LEN)) begin
              fill[cur_ch] <= fill[cur_ch] + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid) begin
      cur_ch <= job_item.channel;
      cur_x  <= SAMPLE_BITS'(job_item.sample);
      tap    <= '0;
      acc    <= '0;
      rp     <= (wptr[job_item.channel] == '0) ? PTR_W'(HIST_LEN - 1)
                                               : wptr[job_item.channel] - 1'b1;
    end
    if (state == ST_RUN) begin
      s1_tap <= tap;
      tap    <= tap + 1'b1;
      // The read for tap t goes out while tap t is issued; the pointer walks
      // back from the newest entry once the new-sample tap has gone.
      if (tap != '0) begin
        rp <= (rp == '0) ? PTR_W'(HIST_LEN - 1) : rp - 1'b1;
      end
    end
    if (s1_vld) begin
      prod <= prod_next;
    end
    if (s2_vld) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == ST_FINISH && can_load) begin
      result_item.channel_out <= cur_ch;
      result_item.filtered    <= tcfir_pkg::SAMPLE_FIELD_W'(y_sat);
      result_item.clipped     <= clip;
    end
  end

endmodule
`default_nettype wire

[design/two_channel_fir_lowpass_unit.sv]
// Two-channel symmetric low-pass FIR unit for optical sensor samples.
// Each request is filtered by the single multiply-accumulate unit stepping one
// tap per cycle; the engine takes the next request from the queue only once
// the result is loaded, which waits while an earlier result is unaccepted.
// Reset (synchronous, active high) empties the queue and marks both delay
// lines empty, so unwritten history reads as zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module two_channel_fir_lowpass_unit #(
  parameter int TAP_COUNT   = tcfir_pkg::TAP_COUNT_DEF,
  parameter int SAMPLE_BITS = tcfir_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = tcfir_pkg::COEF_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output      logic                 sample_ready,
  input  wire tcfir_pkg::in_item_t  sample_item,
  output      logic                 result_valid,
  input  wire logic                 result_ready,
  output      tcfir_pkg::out_item_t result_item
);

  logic                job_valid;
  logic                job_ready;
  tcfir_pkg::in_item_t job_item;

  tcfir_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job_item     (job_item)
  );

  tcfir_back #(
    .TAP_COUNT   (TAP_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job_item     (job_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
`default_nettype wire
